// ----- sv/dps_pkg.sv -----
// Package for the dynamic priority scheduler: field widths, command and
// status codes, and the controller/datapath interface structs.
// No dependencies.
package dps_pkg;

    localparam int DEF_SLOTS = 8;

    localparam int PRIO_W   = 16;
    localparam int TIME_W   = 8;
    localparam int STATUS_W = 3;
    localparam int SLOTID_W = 3;
    localparam int QCOUNT_W = 4;

    localparam logic CMD_ADMIT = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ADMITTED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_TIME  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DISPATCHED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd4;

    localparam logic [PRIO_W-1:0] PRIO_MIN = 16'h8000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // register the incoming request
        logic admit;      // insert the new process and mark its slot busy
        logic pop;        // move the queue head into the hold registers
        logic requeue;    // reinsert the held process with aged priority
        logic retire;     // free the held process's slot
        logic out_admit;  // load an admit result into the output register
        logic out_tick;   // load a tick result into the output register
        logic out_empty;  // the tick found the queue empty
    } dps_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cmd_tick;
        logic full;
        logic need_zero;
        logic empty;
        logic hold_done;
    } dps_stat_t;

endpackage

// ----- sv/dps_ctrl.sv -----
// Controller state machine of the dynamic priority scheduler.
// Depends on dps_pkg for the command and status structs.
module dps_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  dps_pkg::dps_stat_t stat,
    output dps_pkg::dps_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ADMIT = 2'd1;
    localparam logic [1:0] S_POP   = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       empty_reg, empty_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        empty_next = empty_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_POP;
                end
            end
            S_POP: begin
                // Admits pass through here on their way to
                // S_ADMIT; a tick removes the queue head in this cycle.
                if (!stat.cmd_tick) begin
                    state_next = S_ADMIT;
                end else begin
                    empty_next = stat.empty;
                    cmd.pop    = !stat.empty;
                    state_next = S_FIN;
                end
            end
            S_ADMIT: begin
                if (out_free) begin
                    cmd.admit     = !stat.full && !stat.need_zero;
                    cmd.out_admit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    cmd.out_tick  = 1'b1;
                    cmd.out_empty = empty_reg;
                    cmd.retire    = !empty_reg && stat.hold_done;
                    cmd.requeue   = !empty_reg && !stat.hold_done;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.out_admit || cmd.out_tick) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            empty_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            empty_reg   <= empty_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- sv/dps_dpath.sv -----
// Datapath of the dynamic priority scheduler: sorted cell chain, slot map,
// hold registers for the dispatched process and the result register.
// Depends on dps_pkg for widths, codes and the interface structs.
module dps_dpath #(
    parameter int SLOTS = dps_pkg::DEF_SLOTS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_command,
    input  logic signed [dps_pkg::PRIO_W-1:0]   s_priority_req,
    input  logic        [dps_pkg::TIME_W-1:0]   s_need_time,
    input  dps_pkg::dps_cmd_t                   cmd,
    output dps_pkg::dps_stat_t                  stat,
    output logic        [dps_pkg::STATUS_W-1:0] m_status,
    output logic        [dps_pkg::SLOTID_W-1:0] m_slot_id,
    output logic signed [dps_pkg::PRIO_W-1:0]   m_run_priority,
    output logic        [dps_pkg::TIME_W-1:0]   m_run_time,
    output logic                                m_finished,
    output logic        [dps_pkg::QCOUNT_W-1:0] m_queue_count
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int PW = dps_pkg::PRIO_W;
    localparam int TW = dps_pkg::TIME_W;

    // Captured request.
    logic                 in_cmd_reg;
    logic signed [PW-1:0] in_prio_reg;
    logic [TW-1:0]        in_need_reg;

    // Queue cells, head at index 0.
    logic signed [PW-1:0] prio_reg [SLOTS];
    logic [TW-1:0]        need_reg [SLOTS];
    logic [TW-1:0]        run_reg  [SLOTS];
    logic [SW-1:0]        slot_reg [SLOTS];
    logic [SLOTS-1:0]     valid_reg;
    logic signed [PW-1:0] prio_next [SLOTS];
    logic [TW-1:0]        need_next [SLOTS];
    logic [TW-1:0]        run_next  [SLOTS];
    logic [SW-1:0]        slot_next [SLOTS];
    logic [SLOTS-1:0]     valid_next;

    logic [SLOTS-1:0] busy_reg, busy_next;
    logic [CW-1:0]    count_reg, count_next;

    // Dispatched process.
    logic signed [PW-1:0] hold_prio_reg;
    logic [TW-1:0]        hold_need_reg;
    logic [TW-1:0]        hold_run_reg;
    logic [SW-1:0]        hold_slot_reg;

    // Insertion value and per-cell neighbours.
    logic                 insert;
    logic signed [PW-1:0] ins_prio, aged_prio;
    logic [TW-1:0]        ins_need, ins_run;
    logic [SW-1:0]        ins_slot, free_slot;
    logic [SLOTS-1:0]     ge, prev_ge, prev_valid, below_valid;

    logic [31:0] slot_wide, count_wide;

    assign stat.cmd_tick  = (in_cmd_reg == dps_pkg::CMD_TICK);
    assign stat.full      = (count_reg == CW'(SLOTS));
    assign stat.need_zero = (in_need_reg == '0);
    assign stat.empty     = (count_reg == '0);
    assign stat.hold_done = (hold_run_reg == hold_need_reg);

    // Lowest free slot.
    always_comb begin
        free_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                free_slot = SW'(i);
            end
        end
    end

    assign aged_prio = (hold_prio_reg == dps_pkg::PRIO_MIN) ? hold_prio_reg
                                                            : hold_prio_reg - PW'(1);
    assign insert    = cmd.admit || cmd.requeue;
    assign ins_prio  = cmd.admit ? in_prio_reg : aged_prio;
    assign ins_need  = cmd.admit ? in_need_reg : hold_need_reg;
    assign ins_run   = cmd.admit ? '0 : hold_run_reg;
    assign ins_slot  = cmd.admit ? free_slot : hold_slot_reg;

    // Each cell keeps its entry when it ranks at or above the newcomer,
    // takes the newcomer when it is the first cell that does not, and
    // otherwise takes its upper neighbour's entry. A pop shifts up.
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            ge[i] = valid_reg[i] && (prio_reg[i] >= ins_prio);
        end
        prev_ge[0]    = 1'b1;
        prev_valid[0] = 1'b1;
        for (int i = 1; i < SLOTS; i++) begin
            prev_ge[i]    = ge[i-1];
            prev_valid[i] = valid_reg[i-1];
        end
        for (int i = 0; i < SLOTS - 1; i++) begin
            below_valid[i] = valid_reg[i+1];
        end
        below_valid[SLOTS-1] = 1'b0;

        for (int i = 0; i < SLOTS; i++) begin
            prio_next[i]  = prio_reg[i];
            need_next[i]  = need_reg[i];
            run_next[i]   = run_reg[i];
            slot_next[i]  = slot_reg[i];
            valid_next[i] = valid_reg[i];
            if (cmd.pop) begin
                valid_next[i] = below_valid[i];
                if (i < SLOTS - 1) begin
                    prio_next[i] = prio_reg[(i < SLOTS - 1) ? i + 1 : i];
                    need_next[i] = need_reg[(i < SLOTS - 1) ? i + 1 : i];
                    run_next[i]  = run_reg[(i < SLOTS - 1) ? i + 1 : i];
                    slot_next[i] = slot_reg[(i < SLOTS - 1) ? i + 1 : i];
                end
            end else if (insert) begin
                valid_next[i] = valid_reg[i] || prev_valid[i];
                if (!ge[i]) begin
                    if (prev_ge[i]) begin
                        prio_next[i] = ins_prio;
                        need_next[i] = ins_need;
                        run_next[i]  = ins_run;
                        slot_next[i] = ins_slot;
                    end else begin
                        prio_next[i] = prio_reg[(i > 0) ? i - 1 : i];
                        need_next[i] = need_reg[(i > 0) ? i - 1 : i];
                        run_next[i]  = run_reg[(i > 0) ? i - 1 : i];
                        slot_next[i] = slot_reg[(i > 0) ? i - 1 : i];
                    end
                end
            end
        end
    end

    always_comb begin
        busy_next = busy_reg;
        if (cmd.admit) begin
            busy_next[free_slot] = 1'b1;
        end
        if (cmd.retire) begin
            busy_next[hold_slot_reg] = 1'b0;
        end
    end

    always_comb begin
        priority if (insert) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.pop) begin
            count_next = count_reg - 1'b1;
        end else begin
            count_next = count_reg;
        end
    end

    assign slot_wide  = 32'(cmd.admit ? free_slot : hold_slot_reg);
    assign count_wide = 32'(count_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            busy_reg  <= '0;
            count_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < SLOTS; i++) begin
            prio_reg[i] <= prio_next[i];
            need_reg[i] <= need_next[i];
            run_reg[i]  <= run_next[i];
            slot_reg[i] <= slot_next[i];
        end
        if (cmd.capture) begin
            in_cmd_reg  <= s_command;
            in_prio_reg <= s_priority_req;
            in_need_reg <= s_need_time;
        end
        if (cmd.pop) begin
            hold_prio_reg <= prio_reg[0];
            hold_need_reg <= need_reg[0];
            hold_run_reg  <= run_reg[0] + 1'b1;
            hold_slot_reg <= slot_reg[0];
        end
        if (cmd.out_admit) begin
            m_run_priority <= '0;
            m_run_time     <= '0;
            m_finished     <= 1'b0;
            m_queue_count  <= count_wide[dps_pkg::QCOUNT_W-1:0];
            if (stat.full) begin
                m_status  <= dps_pkg::ST_FULL;
                m_slot_id <= '0;
            end else if (stat.need_zero) begin
                m_status  <= dps_pkg::ST_ZERO_TIME;
                m_slot_id <= '0;
            end else begin
                m_status  <= dps_pkg::ST_ADMITTED;
                m_slot_id <= slot_wide[dps_pkg::SLOTID_W-1:0];
            end
        end else if (cmd.out_tick) begin
            m_queue_count <= count_wide[dps_pkg::QCOUNT_W-1:0];
            if (cmd.out_empty) begin
                m_status       <= dps_pkg::ST_EMPTY;
                m_slot_id      <= '0;
                m_run_priority <= '0;
                m_run_time     <= '0;
                m_finished     <= 1'b0;
            end else begin
                m_status       <= dps_pkg::ST_DISPATCHED;
                m_slot_id      <= slot_wide[dps_pkg::SLOTID_W-1:0];
                m_run_priority <= hold_prio_reg;
                m_run_time     <= hold_run_reg;
                m_finished     <= stat.hold_done;
            end
        end
    end

endmodule

// ----- sv/dynamic_priority_scheduler_top.sv -----
// Top level of the dynamic priority scheduler: controller plus datapath.
// Depends on dps_pkg, dps_ctrl and dps_dpath.
//
// The block keeps a ready queue of up to SLOTS processes in a chain of
// cells sorted by priority, largest first, with earlier arrivals ahead of
// later ones of equal priority. An admit request (command 0) takes the
// lowest free slot and is inserted behind every entry of equal or higher
// priority; it is refused with status full when all slots are busy, and
// with status zero time when its need is zero. A tick request (command 1)
// removes the head, advances its run time by one and either retires it,
// freeing its slot, or requeues it one priority lower (the minimum
// priority stays put). A request is accepted in the idle state only, and
// each request yields exactly one result. Both kinds of request follow
// the controller's sequence: capture, then a state in which a tick
// removes the head and an admit only passes through, then, once the
// output register is free, at most one insertion into the cell chain in
// the cycle that loads the result register. The controller is idle again
// in the cycle after that and takes no new request before it is through
// with the last one. A new request is taken while a result still waits
// in the output register; its own result waits until that register is
// free.
module dynamic_priority_scheduler_top #(
    parameter int SLOTS = dps_pkg::DEF_SLOTS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic signed [dps_pkg::PRIO_W-1:0]   s_priority_req,
    input  logic        [dps_pkg::TIME_W-1:0]   s_need_time,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic        [dps_pkg::STATUS_W-1:0] m_status,
    output logic        [dps_pkg::SLOTID_W-1:0] m_slot_id,
    output logic signed [dps_pkg::PRIO_W-1:0]   m_run_priority,
    output logic        [dps_pkg::TIME_W-1:0]   m_run_time,
    output logic                                m_finished,
    output logic        [dps_pkg::QCOUNT_W-1:0] m_queue_count
);

    // Command and status between the controller and the datapath.
    dps_pkg::dps_cmd_t  cmd;
    dps_pkg::dps_stat_t stat;

    // The controller sequences each request and owns both handshakes.
    dps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // The datapath holds the sorted queue, the slot map and the result.
    dps_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_command      (s_command),
        .s_priority_req (s_priority_req),
        .s_need_time    (s_need_time),
        .cmd            (cmd),
        .stat           (stat),
        .m_status       (m_status),
        .m_slot_id      (m_slot_id),
        .m_run_priority (m_run_priority),
        .m_run_time     (m_run_time),
        .m_finished     (m_finished),
        .m_queue_count  (m_queue_count)
    );

endmodule

// ----- dv/dynamic_priority_scheduler_top_tb.sv -----
// Self-checking testbench for the dynamic priority scheduler top level.
// Depends on dps_pkg and dynamic_priority_scheduler_top; it predicts every
// result with its own model of the sorted ready queue and checks it.
module dynamic_priority_scheduler_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = dps_pkg::DEF_SLOTS;
    localparam int PRIO_W      = dps_pkg::PRIO_W;
    localparam int TIME_W      = dps_pkg::TIME_W;
    localparam int STATUS_W    = dps_pkg::STATUS_W;
    localparam int SLOTID_W    = dps_pkg::SLOTID_W;
    localparam int QCOUNT_W    = dps_pkg::QCOUNT_W;
    // Cycles with no request accepted on either side before the run is given up.
    localparam int STALL_LIMIT = 1000;
    localparam int TAIL_CYCLES = 10;
    localparam int RANDOM_REQS = 1400;

    // One result as the block presents it on the m_ side.
    typedef struct {
        logic [STATUS_W-1:0]      status;
        logic [SLOTID_W-1:0]      slot_id;
        logic signed [PRIO_W-1:0] run_priority;
        logic [TIME_W-1:0]        run_time;
        logic                     finished;
        logic [QCOUNT_W-1:0]      queue_count;
    } sched_result_t;

    // One row of the directed table. Where typed is set, the expected result
    // is written into the row; otherwise the queue model supplies it.
    typedef struct {
        logic                     command;
        logic signed [PRIO_W-1:0] priority_req;
        logic [TIME_W-1:0]        need_time;
        bit                       typed;
        sched_result_t            want;
    } plan_row_t;

    logic                       aclk;
    logic                       aresetn        = 1'b0;
    logic                       s_valid        = 1'b0;
    logic                       s_ready;
    logic                       s_command      = dps_pkg::CMD_ADMIT;
    logic signed [PRIO_W-1:0]   s_priority_req = '0;
    logic [TIME_W-1:0]          s_need_time    = '0;
    logic                       m_valid;
    logic                       m_ready        = 1'b0;
    logic [STATUS_W-1:0]        m_status;
    logic [SLOTID_W-1:0]        m_slot_id;
    logic signed [PRIO_W-1:0]   m_run_priority;
    logic [TIME_W-1:0]          m_run_time;
    logic                       m_finished;
    logic [QCOUNT_W-1:0]        m_queue_count;

    // Model of the ready queue, head at position 0, in queue order.
    logic signed [PRIO_W-1:0]   ready_prio [SLOTS];
    logic [TIME_W-1:0]          ready_need [SLOTS];
    logic [TIME_W-1:0]          ready_run  [SLOTS];
    int                         ready_slot [SLOTS];
    int                         ready_len;
    logic [SLOTS-1:0]           slot_busy;

    sched_result_t              pending_results [$];
    plan_row_t                  directed_plan [$];
    bit                         gaps_on = 1'b1;
    bit                         failed  = 1'b0;
    int                         stall_cycles = 0;

    dynamic_priority_scheduler_top #(
        .SLOTS(SLOTS)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_priority_req (s_priority_req),
        .s_need_time    (s_need_time),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_slot_id      (m_slot_id),
        .m_run_priority (m_run_priority),
        .m_run_time     (m_run_time),
        .m_finished     (m_finished),
        .m_queue_count  (m_queue_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Places a process behind every queued entry of equal or higher priority,
    // so that equal priorities are served in the order they were queued.
    function automatic void queue_insert(logic signed [PRIO_W-1:0] prio,
                                         logic [TIME_W-1:0] need,
                                         logic [TIME_W-1:0] run, int slot);
        int pos;
        pos = 0;
        while (pos < ready_len && ready_prio[pos] >= prio) pos++;
        for (int i = ready_len; i > pos; i--) begin
            ready_prio[i] = ready_prio[i-1];
            ready_need[i] = ready_need[i-1];
            ready_run[i]  = ready_run[i-1];
            ready_slot[i] = ready_slot[i-1];
        end
        ready_prio[pos] = prio;
        ready_need[pos] = need;
        ready_run[pos]  = run;
        ready_slot[pos] = slot;
        ready_len++;
    endfunction

    // Applies one accepted request to the queue model and returns the result
    // the block must give for it.
    function automatic sched_result_t schedule_step(logic cmd,
                                                    logic signed [PRIO_W-1:0] prio,
                                                    logic [TIME_W-1:0] need);
        sched_result_t            res;
        int                       slot;
        logic signed [PRIO_W-1:0] head_prio;
        logic [TIME_W-1:0]        head_need;
        logic [TIME_W-1:0]        head_run;
        res.status       = dps_pkg::ST_ADMITTED;
        res.slot_id      = '0;
        res.run_priority = '0;
        res.run_time     = '0;
        res.finished     = 1'b0;
        if (cmd == dps_pkg::CMD_ADMIT) begin
            // A full table wins over a zero need.
            if (ready_len >= SLOTS) begin
                res.status = dps_pkg::ST_FULL;
            end else if (need == 0) begin
                res.status = dps_pkg::ST_ZERO_TIME;
            end else begin
                slot = 0;
                while (slot < SLOTS && slot_busy[slot]) slot++;
                if (slot >= SLOTS) begin
                    res.status = dps_pkg::ST_FULL;
                end else begin
                    slot_busy[slot] = 1'b1;
                    queue_insert(prio, need, '0, slot);
                    res.slot_id = SLOTID_W'(slot);
                end
            end
        end else if (ready_len == 0) begin
            res.status = dps_pkg::ST_EMPTY;
        end else begin
            head_prio = ready_prio[0];
            head_need = ready_need[0];
            head_run  = ready_run[0] + 1'b1;
            slot      = ready_slot[0];
            for (int i = 0; i + 1 < ready_len; i++) begin
                ready_prio[i] = ready_prio[i+1];
                ready_need[i] = ready_need[i+1];
                ready_run[i]  = ready_run[i+1];
                ready_slot[i] = ready_slot[i+1];
            end
            ready_len--;
            res.status       = dps_pkg::ST_DISPATCHED;
            res.slot_id      = SLOTID_W'(slot);
            res.run_priority = head_prio;
            res.run_time     = head_run;
            if (head_run == head_need) begin
                res.finished    = 1'b1;
                slot_busy[slot] = 1'b0;
            end else begin
                // Ageing: one step lower, but never below the minimum.
                queue_insert((head_prio == dps_pkg::PRIO_MIN) ? head_prio
                                                              : head_prio - 1'b1,
                             head_need, head_run, slot);
            end
        end
        res.queue_count = QCOUNT_W'(ready_len);
        return res;
    endfunction

    function automatic plan_row_t plan_entry(logic cmd, logic signed [PRIO_W-1:0] prio,
                                             logic [TIME_W-1:0] need, bit typed,
                                             logic [STATUS_W-1:0] status,
                                             logic [SLOTID_W-1:0] slot,
                                             logic signed [PRIO_W-1:0] run_prio,
                                             logic [TIME_W-1:0] run_time, logic fin,
                                             logic [QCOUNT_W-1:0] count);
        plan_row_t row;
        row.command           = cmd;
        row.priority_req      = prio;
        row.need_time         = need;
        row.typed             = typed;
        row.want.status       = status;
        row.want.slot_id      = slot;
        row.want.run_priority = run_prio;
        row.want.run_time     = run_time;
        row.want.finished     = fin;
        row.want.queue_count  = count;
        return row;
    endfunction

    // Presents one request, holding it until the block takes it, and returns
    // the predicted result. The sender may first idle with valid low; when
    // it does not, valid simply stays high into the next request.
    task automatic send_request(input logic cmd, input logic signed [PRIO_W-1:0] prio,
                                input logic [TIME_W-1:0] need,
                                output sched_result_t predicted);
        int idle;
        idle = 0;
        while (gaps_on && $urandom_range(99) < 7) idle++;
        if (idle > 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_command      <= cmd;
        s_priority_req <= prio;
        s_need_time    <= need;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = schedule_step(cmd, prio, need);
    endtask

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            failed = 1'b1;
        end
    endtask

    // Result side: random back-pressure, checking against the oldest
    // expectation, and the watchdog. Everything read here is the value from
    // before the edge, as all drivers use nonblocking assignments.
    always @(posedge aclk) begin
        sched_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !gaps_on || ($urandom_range(99) >= 7);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with status %0d arrived with none expected",
                             $time, m_status);
                    failed = 1'b1;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("status", want.status, m_status);
                    compare_field("slot_id", want.slot_id, m_slot_id);
                    compare_field("run_priority", want.run_priority, m_run_priority);
                    compare_field("run_time", want.run_time, m_run_time);
                    compare_field("finished", want.finished, m_finished);
                    compare_field("queue_count", want.queue_count, m_queue_count);
                end
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        sched_result_t            predicted;
        logic                     cmd;
        logic signed [PRIO_W-1:0] prio;
        logic [TIME_W-1:0]        need;
        int                       admit_pct;
        int                       pick;

        ready_len = 0;
        slot_busy = '0;

        // The directed table. It opens on the empty queue and a zero need,
        // then runs one process at the minimum priority twice so that the
        // ageing floor shows in the second dispatch. Next the table is filled
        // with both priority extremes and a pair of equal priorities, both
        // kinds of refusal are tried on the full table (full must win over a
        // zero need), the top process is retired and the freed lowest slot is
        // taken again. The closing ticks walk the queue through requeueing
        // behind equals and are left to the model.
        // Columns: command, priority, need, typed, status, slot, run priority,
        // run time, finished, queue count.
        directed_plan.push_back(plan_entry(dps_pkg::CMD_TICK, 16'sd0, 8'd0, 1'b1,
                                           dps_pkg::ST_EMPTY, 3'd0, 16'sd0, 8'd0,
                                           1'b0, 4'd0));
        directed_plan.push_back(plan_entry(dps_pkg::CMD_ADMIT, 16'sd5, 8'd0, 1'b1,
                                           dps_pkg::ST_ZERO_TIME, 3'd0, 16'sd0, 8'd0,
                                           1'b0, 4'd0));
        directed_plan.push_back(plan_entry(dps_pkg::CMD_ADMIT, 16'sh8000, 8'd2, 1'b1,
                                           dps_pkg::ST_ADMITTED, 3'd0, 16'sd0, 8'd0,
                                           1'b0, 4'd1));
        directed_plan.push_back(plan_entry(dps_pkg::CMD_TICK, 16'sd0, 8'd0, 1'b1,
                                           dps_pkg::ST_DISPATCHED, 3'd0, 16'sh8000, 8'd1,
                                           1'b0, 4'd1));
        directed_plan.push_back(plan_entry(dps_pkg::CMD_TICK, 16'sd0, 8'd0, 1'b1,
                                           dps_pkg::ST_DISPATCHED, 3'd0, 16'sh8000, 8'd2,
                                           1'b1, 4'd0));
        directed_plan.push_back(plan_entry(dps_pkg::CMD_ADMIT, 16'sh7FFF, 8'd1, 1'b1,
                                           dps_pkg::ST_ADMITTED, 3'd0, 16'sd0, 8'd0,
                                           1'b0, 4'd1));
        directed_plan.push_back(plan_entry(dps_pkg::CMD_ADMIT, 16'sh8000, 8'hFF, 1'b1,
                                           dps_pkg::ST_ADMITTED, 3'd1, 16'sd0, 8'd0,
                                           1'b0, 4'd2));
        directed_plan.push_back(plan_entry(dps_pkg::CMD_ADMIT, 16'sd0, 8'd2, 1'b1,
                                           dps_pkg::ST_ADMITTED, 3'd2, 16'sd0, 8'd0,
                                           1'b0, 4'd3));
        directed_plan.push_back(plan_entry(dps_pkg::CMD_ADMIT, 16'sd0, 8'd3, 1'b1,
                                           dps_pkg::ST_ADMITTED, 3'd3, 16'sd0, 8'd0,
                                           1'b0, 4'd4));
        directed_plan.push_back(plan_entry(dps_pkg::CMD_ADMIT, -16'sd1, 8'd1, 1'b1,
                                           dps_pkg::ST_ADMITTED, 3'd4, 16'sd0, 8'd0,
                                           1'b0, 4'd5));
        directed_plan.push_back(plan_entry(dps_pkg::CMD_ADMIT, 16'sd1, 8'd4, 1'b1,
                                           dps_pkg::ST_ADMITTED, 3'd5, 16'sd0, 8'd0,
                                           1'b0, 4'd6));
        directed_plan.push_back(plan_entry(dps_pkg::CMD_ADMIT, 16'sh8001, 8'd2, 1'b1,
                                           dps_pkg::ST_ADMITTED, 3'd6, 16'sd0, 8'd0,
                                           1'b0, 4'd7));
        directed_plan.push_back(plan_entry(dps_pkg::CMD_ADMIT, 16'sd100, 8'd1, 1'b1,
                                           dps_pkg::ST_ADMITTED, 3'd7, 16'sd0, 8'd0,
                                           1'b0, 4'd8));
        directed_plan.push_back(plan_entry(dps_pkg::CMD_ADMIT, 16'sd3, 8'd5, 1'b1,
                                           dps_pkg::ST_FULL, 3'd0, 16'sd0, 8'd0,
                                           1'b0, 4'd8));
        directed_plan.push_back(plan_entry(dps_pkg::CMD_ADMIT, 16'sd3, 8'd0, 1'b1,
                                           dps_pkg::ST_FULL, 3'd0, 16'sd0, 8'd0,
                                           1'b0, 4'd8));
        directed_plan.push_back(plan_entry(dps_pkg::CMD_TICK, 16'sd0, 8'd0, 1'b1,
                                           dps_pkg::ST_DISPATCHED, 3'd0, 16'sh7FFF, 8'd1,
                                           1'b1, 4'd7));
        directed_plan.push_back(plan_entry(dps_pkg::CMD_ADMIT, 16'sd0, 8'd1, 1'b1,
                                           dps_pkg::ST_ADMITTED, 3'd0, 16'sd0, 8'd0,
                                           1'b0, 4'd8));
        // The fields of a tick request are ignored, so they carry toggling bits.
        repeat (8) begin
            directed_plan.push_back(plan_entry(dps_pkg::CMD_TICK, 16'shAAAA, 8'h55, 1'b0,
                                               dps_pkg::ST_ADMITTED, 3'd0, 16'sd0, 8'd0,
                                               1'b0, 4'd0));
        end

        // Synchronous reset, then it is released and left to settle before
        // the first request is offered.
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_plan[i]) begin
            send_request(directed_plan[i].command, directed_plan[i].priority_req,
                         directed_plan[i].need_time, predicted);
            pending_results.push_back(directed_plan[i].typed ? directed_plan[i].want
                                                             : predicted);
        end

        // Random part. The mix of admits and ticks swings between phases so
        // that the queue is driven to full, drained to empty and held in
        // between. Priorities mostly come from a narrow band so that equal
        // priorities and requeueing behind equals are common; a few sit at
        // the extremes to reach the ageing floor. Most needs are short so that
        // processes retire and slots are reused.
        for (int n = 0; n < RANDOM_REQS; n++) begin
            gaps_on = !(n >= 500 && n < 800);
            case ((n / 150) % 3)
                0:       admit_pct = 70;
                1:       admit_pct = 30;
                default: admit_pct = 50;
            endcase
            cmd = ($urandom_range(99) < admit_pct) ? dps_pkg::CMD_ADMIT : dps_pkg::CMD_TICK;
            if (cmd == dps_pkg::CMD_ADMIT) begin
                pick = $urandom_range(9);
                if (pick == 0) begin
                    prio = PRIO_W'($urandom);
                end else if (pick == 1) begin
                    prio = $urandom_range(1) ? dps_pkg::PRIO_MIN : 16'sh7FFF;
                end else begin
                    prio = PRIO_W'(int'($urandom_range(6)) - 3);
                end
                pick = $urandom_range(99);
                if (pick < 5) begin
                    need = '0;
                end else if (pick < 10) begin
                    need = TIME_W'($urandom_range(255));
                end else begin
                    need = TIME_W'($urandom_range(4, 1));
                end
            end else begin
                prio = PRIO_W'($urandom);
                need = TIME_W'($urandom);
            end
            send_request(cmd, prio, need, predicted);
            pending_results.push_back(predicted);
        end
        s_valid <= 1'b0;

        // Drain every outstanding result, then wait out the tail period for anything
        // spurious to appear before the verdict.
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (!failed) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
